@@ hdl/tcp_out_of_order_reassembly_table_core_macros.svh @@
// Assertion macros for the reassembly table core.
`ifndef TCP_OUT_OF_ORDER_REASSEMBLY_TABLE_CORE_MACROS_SVH
`define TCP_OUT_OF_ORDER_REASSEMBLY_TABLE_CORE_MACROS_SVH

// Check that cons holds in the cycle where ante holds.
`define TOOR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("reassembly table check failed");

// Check that cons holds in the cycle after ante.
`define TOOR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("reassembly table check failed");

`endif

@@ hdl/toor_pkg.sv @@
// Types and constants shared by the reassembly table core.
`timescale 1ns / 1ps
`default_nettype none
package toor_pkg;

    localparam int MAX_PKT_LIMIT = 32'hFFFF;
    localparam int MAX_RESULTS   = 32;

    typedef enum logic [2:0] {
        ST_QUEUED = 3'd0,
        ST_DUP    = 3'd1,
        ST_OVF    = 3'd2,
        ST_DELIV  = 3'd3,
        ST_NONE   = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_TAIL,
        S_SRCH,
        S_PREV,
        S_SCAN,
        S_FIX,
        S_MV_RD,
        S_MV_WR,
        S_NEW,
        S_RESP,
        S_DR_CHK,
        S_DR_EV,
        S_DR_FIN
    } t_state;

    typedef struct packed {
        logic [31:0] start_seq;
        logic [31:0] end_seq;
        logic        fin;
    } t_entry;

    typedef struct packed {
        t_status     status;
        logic [31:0] out_start;
        logic [31:0] out_end;
        logic        out_fin;
        logic [31:0] total_len;
        logic [31:0] next_seq;
        logic        last;
    } t_result;

endpackage
`default_nettype wire

@@ hdl/toor_if.sv @@
// Handshake channel interfaces of the reassembly table core.
`timescale 1ns / 1ps
`default_nettype none
interface toor_cmd_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [31:0] seg_start;
    logic [31:0] seg_end;
    logic        seg_fin;
    logic [31:0] expected_seq;
    modport source (output valid, command, seg_start, seg_end, seg_fin, expected_seq,
                    input ready);
    modport sink (input valid, command, seg_start, seg_end, seg_fin, expected_seq,
                  output ready);
endinterface

interface toor_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] out_start;
    logic [31:0] out_end;
    logic        out_fin;
    logic [31:0] total_len;
    logic [31:0] next_seq;
    logic        last;
    modport source (output valid, status, out_start, out_end, out_fin, total_len,
                    next_seq, last, input ready);
    modport sink (input valid, status, out_start, out_end, out_fin, total_len,
                  next_seq, last, output ready);
endinterface

interface toor_cfg_if;
    logic       valid;
    logic       ready;
    logic [5:0] max_entries;
    modport source (output valid, max_entries, input ready);
    modport sink (input valid, max_entries, output ready);
endinterface
`default_nettype wire

@@ hdl/tcp_out_of_order_reassembly_table_core.sv @@
// Insert: an append reads the tail and writes behind it; else search, scan, shift and write.
// Drain: entries are delivered one by one, paced by the single memory read port.
// Throughput: one item at a time; insert and drain walk the table one entry per step.
// Each mid-table move reads each shifted entry, then writes it back.
// Reset clears the entry count, head pointer and output valid; max_entries = 32.
// Entry memory is not cleared; only entries below the count are ever read.
`timescale 1ns / 1ps
`default_nettype none
`include "tcp_out_of_order_reassembly_table_core_macros.svh"
module tcp_out_of_order_reassembly_table_core
    import toor_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    toor_cmd_if.sink   i_cmd,
    toor_res_if.source o_res,
    toor_cfg_if.sink   i_cfg
);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // Map a logical position onto the circular buffer behind the head.
    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] head,
                                            input logic [CW-1:0] x);
        logic [CW:0] sum;
        sum = {{(CW + 1 - AW){1'b0}}, head} + {1'b0, x};
        if (sum >= (CW + 1)'(TABLE_DEPTH)) begin
            sum = sum - (CW + 1)'(TABLE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    t_state      r_state, n_state;
    logic        r_drain, n_drain;
    logic [31:0] r_s, n_s;
    logic [31:0] r_e, n_e;
    logic        r_f, n_f;
    logic [31:0] r_next, n_next;
    logic [31:0] r_total, n_total;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_k, n_k;
    logic [CW-1:0] r_src, n_src;
    logic [CW-1:0] r_dst, n_dst;
    logic [CW-1:0] r_newcnt, n_newcnt;
    logic        r_up, n_up;
    logic        r_trunc, n_trunc;
    logic        r_modk, n_modk;
    t_entry      r_prev, n_prev;
    t_status     r_status, n_status;
    logic [5:0]  r_n, n_n;
    logic        r_have, n_have;
    t_result     r_pend, n_pend;
    t_result     r_out, n_out;
    logic        r_ovalid, n_ovalid;
    logic [5:0]  r_max;

    logic          w_we, w_re;
    logic [AW-1:0] w_waddr, w_raddr;
    t_entry        w_wdata, w_rd;
    logic [31:0]   w_a0, w_b0, w_a1, w_b1;
    logic          w_lt0, w_lt1;
    logic [31:0]   w_limit;
    logic          w_full;
    logic          w_free;
    logic          w_ov;
    logic [CW-1:0] w_tail;
    logic [31:0]   w_len;
    t_entry        w_new;
    t_entry        w_mv;

    toor_mem #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    toor_cmp u_cmp (
        .i_a0  (w_a0),
        .i_b0  (w_b0),
        .i_a1  (w_a1),
        .i_b1  (w_b1),
        .o_lt0 (w_lt0),
        .o_lt1 (w_lt1)
    );

    // Effective entry limit: smallest of the register, the packet cap and the depth.
    always_comb begin
        w_limit = 32'(r_max);
        if (w_limit > 32'(MAX_PKT_LIMIT)) begin
            w_limit = 32'(MAX_PKT_LIMIT);
        end
        if (w_limit > 32'(TABLE_DEPTH)) begin
            w_limit = 32'(TABLE_DEPTH);
        end
    end

    assign w_full = 32'(r_count) >= w_limit;
    assign w_free = !r_ovalid || o_res.ready;
    assign w_ov   = (r_i != '0) && !w_lt0;
    assign w_tail = r_trunc ? '0 : (r_count - r_k);
    assign w_len  = w_rd.end_seq - w_rd.start_seq;
    assign w_new  = '{start_seq: r_s, end_seq: r_e, fin: r_f};

    // Moved entry; the first entry after the covered run gets its head trimmed.
    always_comb begin
        w_mv = w_rd;
        if (r_modk && (r_src == r_k)) begin
            w_mv.start_seq = r_e;
        end
    end

    // Steer the shared compare unit by step.
    always_comb begin
        w_a0 = r_s;
        w_b0 = w_rd.end_seq;
        w_a1 = r_prev.end_seq;
        w_b1 = r_e;
        case (r_state)
            S_TAIL: begin
                w_a0 = r_s;
                w_b0 = w_rd.end_seq;
            end
            S_SRCH: begin
                w_a0 = w_rd.start_seq;
                w_b0 = r_s;
            end
            S_PREV: begin
                w_a0 = r_prev.end_seq;
                w_b0 = r_s;
                w_a1 = r_prev.end_seq;
                w_b1 = r_e;
            end
            S_SCAN: begin
                w_a0 = w_rd.start_seq;
                w_b0 = r_e;
                w_a1 = r_e;
                w_b1 = w_rd.end_seq;
            end
            S_DR_EV: begin
                w_a0 = r_next;
                w_b0 = w_rd.start_seq;
            end
            default: begin
                w_a0 = r_s;
                w_b0 = w_rd.end_seq;
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                if (r_drain) begin
                    n_state = S_DR_CHK;
                end else if (w_full || (r_count == '0)) begin
                    n_state = S_RESP;
                end else begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                n_state = w_lt0 ? S_SRCH : S_RESP;
            end
            S_SRCH: begin
                if (!w_lt0 || ((r_i + CW'(1)) == r_count)) begin
                    n_state = S_PREV;
                end
            end
            S_PREV: begin
                if (w_ov && (!w_lt1 || r_prev.fin)) begin
                    n_state = S_RESP;
                end else if (r_i < r_count) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_FIX;
                end
            end
            S_SCAN: begin
                if (w_lt0 && !w_lt1 && ((r_k + CW'(1)) != r_count)) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                if ((w_tail == '0) || ((r_k == (r_i + CW'(1))) && !r_modk)) begin
                    n_state = S_NEW;
                end else begin
                    n_state = S_MV_RD;
                end
            end
            S_MV_RD: begin
                n_state = S_MV_WR;
            end
            S_MV_WR: begin
                if (r_up ? (r_src == r_k) : ((r_src + CW'(1)) == r_count)) begin
                    n_state = S_NEW;
                end else begin
                    n_state = S_MV_RD;
                end
            end
            S_NEW: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (w_free) begin
                    n_state = S_IDLE;
                end
            end
            S_DR_CHK: begin
                if ((r_count == '0) || (r_n == 6'(MAX_RESULTS))) begin
                    n_state = S_DR_FIN;
                end else begin
                    n_state = S_DR_EV;
                end
            end
            S_DR_EV: begin
                if (w_lt0) begin
                    n_state = S_DR_FIN;
                end else if (!r_have || w_free) begin
                    n_state = S_DR_CHK;
                end
            end
            S_DR_FIN: begin
                if (w_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath, memory port and output register updates.
    always_comb begin
        n_drain  = r_drain;
        n_s      = r_s;
        n_e      = r_e;
        n_f      = r_f;
        n_next   = r_next;
        n_total  = r_total;
        n_count  = r_count;
        n_head   = r_head;
        n_i      = r_i;
        n_k      = r_k;
        n_src    = r_src;
        n_dst    = r_dst;
        n_newcnt = r_newcnt;
        n_up     = r_up;
        n_trunc  = r_trunc;
        n_modk   = r_modk;
        n_prev   = r_prev;
        n_status = r_status;
        n_n      = r_n;
        n_have   = r_have;
        n_pend   = r_pend;
        n_out    = r_out;
        n_ovalid = r_ovalid && !o_res.ready;
        w_we     = 1'b0;
        w_waddr  = f_phys(r_head, r_i);
        w_wdata  = w_new;
        w_re     = 1'b0;
        w_raddr  = f_phys(r_head, r_i);
        case (r_state)
            S_IDLE: begin
                // Latch the item.
                if (i_cmd.valid) begin
                    n_drain = i_cmd.command;
                    n_s     = i_cmd.seg_start;
                    n_e     = i_cmd.seg_end;
                    n_f     = i_cmd.seg_fin;
                    n_next  = i_cmd.expected_seq;
                end
            end
            S_DISP: begin
                if (r_drain) begin
                    n_total = '0;
                    n_n     = '0;
                    n_have  = 1'b0;
                end else if (w_full) begin
                    // Flush the whole table.
                    n_count  = '0;
                    n_status = ST_OVF;
                end else if (r_count == '0) begin
                    w_we     = 1'b1;
                    w_waddr  = f_phys(r_head, '0);
                    n_count  = CW'(1);
                    n_status = ST_QUEUED;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = f_phys(r_head, r_count - CW'(1));
                end
            end
            S_TAIL: begin
                if (!w_lt0) begin
                    // Segment starts at or past the tail end: append unless tail has FIN.
                    if (w_rd.fin) begin
                        n_status = ST_DUP;
                    end else begin
                        w_we     = 1'b1;
                        w_waddr  = f_phys(r_head, r_count);
                        n_count  = r_count + CW'(1);
                        n_status = ST_QUEUED;
                    end
                end else begin
                    n_i     = '0;
                    w_re    = 1'b1;
                    w_raddr = f_phys(r_head, '0);
                end
            end
            S_SRCH: begin
                // Advance past entries that start before the segment.
                if (w_lt0) begin
                    n_prev = w_rd;
                    n_i    = r_i + CW'(1);
                    if ((r_i + CW'(1)) != r_count) begin
                        w_re    = 1'b1;
                        w_raddr = f_phys(r_head, r_i + CW'(1));
                    end
                end
            end
            S_PREV: begin
                n_k     = r_i;
                n_trunc = 1'b0;
                n_modk  = 1'b0;
                if (w_ov && !w_lt1) begin
                    // Segment lies inside the previous entry.
                    if (!r_f) begin
                        n_status = ST_DUP;
                    end else begin
                        w_we     = 1'b1;
                        w_waddr  = f_phys(r_head, r_i - CW'(1));
                        w_wdata  = '{start_seq: r_prev.start_seq, end_seq: r_e, fin: 1'b1};
                        n_count  = r_i;
                        n_status = ST_QUEUED;
                    end
                end else if (w_ov && r_prev.fin) begin
                    n_status = ST_DUP;
                end else begin
                    if (w_ov) begin
                        // Trim the previous entry's tail.
                        w_we    = 1'b1;
                        w_waddr = f_phys(r_head, r_i - CW'(1));
                        w_wdata = '{start_seq: r_prev.start_seq, end_seq: r_s,
                                    fin: r_prev.fin};
                    end
                    if (r_i < r_count) begin
                        w_re    = 1'b1;
                        w_raddr = f_phys(r_head, r_i);
                    end
                end
            end
            S_SCAN: begin
                if (!w_lt0) begin
                    // Segment ends before this entry: FIN drops the rest.
                    n_trunc = r_f;
                end else if (!w_lt1) begin
                    // Fully covered: drop it, carry its FIN over.
                    if (w_rd.fin) begin
                        n_e = w_rd.end_seq;
                        n_f = 1'b1;
                    end
                    n_k = r_k + CW'(1);
                    if ((r_k + CW'(1)) != r_count) begin
                        w_re    = 1'b1;
                        w_raddr = f_phys(r_head, r_k + CW'(1));
                    end
                end else begin
                    n_trunc = r_f;
                    n_modk  = !r_f;
                end
            end
            S_FIX: begin
                n_newcnt = r_i + CW'(1) + w_tail;
                if (r_k == r_i) begin
                    n_up  = 1'b1;
                    n_src = r_count - CW'(1);
                    n_dst = r_count;
                end else begin
                    n_up  = 1'b0;
                    n_src = r_k;
                    n_dst = r_i + CW'(1);
                end
            end
            S_MV_RD: begin
                w_re    = 1'b1;
                w_raddr = f_phys(r_head, r_src);
            end
            S_MV_WR: begin
                w_we    = 1'b1;
                w_waddr = f_phys(r_head, r_dst);
                w_wdata = w_mv;
                if (r_up) begin
                    n_src = r_src - CW'(1);
                    n_dst = r_dst - CW'(1);
                end else begin
                    n_src = r_src + CW'(1);
                    n_dst = r_dst + CW'(1);
                end
            end
            S_NEW: begin
                w_we     = 1'b1;
                w_waddr  = f_phys(r_head, r_i);
                n_count  = r_newcnt;
                n_status = ST_QUEUED;
            end
            S_RESP: begin
                if (w_free) begin
                    n_ovalid = 1'b1;
                    n_out    = '{status: r_status, out_start: '0, out_end: '0,
                                 out_fin: 1'b0, total_len: '0, next_seq: '0, last: 1'b1};
                end
            end
            S_DR_CHK: begin
                if ((r_count != '0) && (r_n != 6'(MAX_RESULTS))) begin
                    w_re    = 1'b1;
                    w_raddr = f_phys(r_head, '0);
                end
            end
            S_DR_EV: begin
                // Pop the head; hold it back until the next one decides last.
                if (!w_lt0 && (!r_have || w_free)) begin
                    if (r_have) begin
                        n_ovalid = 1'b1;
                        n_out    = r_pend;
                    end
                    n_pend  = '{status: ST_DELIV, out_start: w_rd.start_seq,
                                out_end: w_rd.end_seq, out_fin: w_rd.fin,
                                total_len: r_total + w_len, next_seq: r_next + w_len,
                                last: 1'b0};
                    n_total = r_total + w_len;
                    n_next  = r_next + w_len;
                    n_have  = 1'b1;
                    n_n     = r_n + 6'd1;
                    n_head  = f_phys(r_head, CW'(1));
                    n_count = r_count - CW'(1);
                end
            end
            S_DR_FIN: begin
                if (w_free) begin
                    n_ovalid = 1'b1;
                    if (r_have) begin
                        n_out      = r_pend;
                        n_out.last = 1'b1;
                    end else begin
                        n_out = '{status: ST_NONE, out_start: '0, out_end: '0,
                                  out_fin: 1'b0, total_len: '0, next_seq: r_next,
                                  last: 1'b1};
                    end
                end
            end
            default: begin
                n_ovalid = r_ovalid && !o_res.ready;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_head   <= '0;
            r_ovalid <= 1'b0;
            r_have   <= 1'b0;
            r_n      <= '0;
            r_max    <= 6'd32;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_head   <= n_head;
            r_ovalid <= n_ovalid;
            r_have   <= n_have;
            r_n      <= n_n;
            if (i_cfg.valid) begin
                r_max <= i_cfg.max_entries;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_drain  <= n_drain;
        r_s      <= n_s;
        r_e      <= n_e;
        r_f      <= n_f;
        r_next   <= n_next;
        r_total  <= n_total;
        r_i      <= n_i;
        r_k      <= n_k;
        r_src    <= n_src;
        r_dst    <= n_dst;
        r_newcnt <= n_newcnt;
        r_up     <= n_up;
        r_trunc  <= n_trunc;
        r_modk   <= n_modk;
        r_prev   <= n_prev;
        r_status <= n_status;
        r_pend   <= n_pend;
        r_out    <= n_out;
    end

    // Ports.
    assign i_cmd.ready     = (r_state == S_IDLE);
    assign i_cfg.ready     = 1'b1;
    assign o_res.valid     = r_ovalid;
    assign o_res.status    = r_out.status;
    assign o_res.out_start = r_out.out_start;
    assign o_res.out_end   = r_out.out_end;
    assign o_res.out_fin   = r_out.out_fin;
    assign o_res.total_len = r_out.total_len;
    assign o_res.next_seq  = r_out.next_seq;
    assign o_res.last      = r_out.last;

    `TOOR_ASSERT_NOW(a_count_fits, 1'b1, r_count <= CW'(TABLE_DEPTH))
    `TOOR_ASSERT_NEXT(a_flush_on_full, (r_state == S_DISP) && !r_drain && w_full, r_count == '0)
    `TOOR_ASSERT_NOW(a_drain_cap, 1'b1, r_n <= 6'(MAX_RESULTS))
endmodule
`default_nettype wire

@@ hdl/toor_cmp.sv @@
// Shared wrapping sequence compare unit: two a < b tests mod 2^32.
`timescale 1ns / 1ps
`default_nettype none
module toor_cmp (
    input  wire logic [31:0] i_a0,
    input  wire logic [31:0] i_b0,
    input  wire logic [31:0] i_a1,
    input  wire logic [31:0] i_b1,
    output logic             o_lt0,
    output logic             o_lt1
);
    logic [31:0] w_d0;
    logic [31:0] w_d1;

    // a precedes b when the difference has its top bit set
    assign w_d0  = i_a0 - i_b0;
    assign w_d1  = i_a1 - i_b1;
    assign o_lt0 = w_d0[31];
    assign o_lt1 = w_d1[31];
endmodule
`default_nettype wire

@@ hdl/toor_mem.sv @@
// Entry memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module toor_mem
    import toor_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_entry        i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output t_entry             o_rdata
);
    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire
